[hdl/i2p_pkg.sv]
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, constants and character helpers for the infix-to-postfix
// converter: operator stack sizing, character codes, command/status structs.
// ----------------------------------------------------------------------------
package i2p_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	// precedence ranks: -1 maps to 0 so that the order is kept unsigned
	localparam logic [1:0] RANK_NONE  = 2'd0;
	localparam logic [1:0] RANK_ADD   = 2'd1;
	localparam logic [1:0] RANK_MUL   = 2'd2;
	localparam logic [1:0] RANK_POW   = 2'd3;

	typedef enum logic [1:0] {
		CLS_ALNUM,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OTHER
	} char_class_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic load;
		logic push;
		logic pop_drop;
		logic emit_top;
		logic emit_char;
		logic drain;
		logic clear_err;
	} cmd_t;

	typedef struct packed {
		char_class_t cls;
		logic        eos;
		logic        count_zero;
		logic        full;
		logic        top_is_open;
		logic        top_pops;
		logic        pend_valid;
		logic        out_ready;
	} stat_t;

	function automatic logic [1:0] prec_rank(input logic [7:0] ch);
		logic [1:0] r;
		if (ch == CH_CARET)
			r = RANK_POW;
		else if (ch == CH_STAR || ch == CH_SLASH)
			r = RANK_MUL;
		else if (ch == CH_PLUS || ch == CH_MINUS)
			r = RANK_ADD;
		else
			r = RANK_NONE;
		return r;
	endfunction

	function automatic char_class_t char_class(input logic [7:0] ch);
		char_class_t c;
		if ((ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
		    (ch >= 8'h61 && ch <= 8'h7A))
			c = CLS_ALNUM;
		else if (ch == CH_OPEN)
			c = CLS_OPEN;
		else if (ch == CH_CLOSE)
			c = CLS_CLOSE;
		else
			c = CLS_OTHER;
		return c;
	endfunction

	// true when an incoming character pops the stacked entry top
	function automatic logic pops_entry(input logic [7:0] top, input logic [7:0] ch);
		logic p;
		p = (prec_rank(top) >= prec_rank(ch)) && !(ch == CH_CARET && top == CH_CARET);
		return p;
	endfunction

endpackage

[hdl/i2p_dp.sv]
// ----------------------------------------------------------------------------
// i2p_dp
// Datapath: current character, operator stack memory with registered top
// read, depth and bracket counters, sticky error, lookahead and output regs.
// ----------------------------------------------------------------------------
module i2p_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  i2p_pkg::cmd_t cmd,
	output i2p_pkg::stat_t stat,
	input  logic [7:0]    in_char,
	input  logic          end_of_string,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_char,
	output logic          run_last,
	output logic          error_seen
);
	import i2p_pkg::*;

	logic [7:0]       stack_mem [STACK_DEPTH];
	logic [7:0]       top_q;
	logic [7:0]       ch_q;
	logic             eos_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] count_m1;
	logic [PTR_W-1:0] rd_addr;
	logic [CNT_W-1:0] paren_q;
	logic             err_q;
	logic             item_err;
	logic             pop;
	logic             emit;
	logic             full;
	logic             pend_valid_q;
	logic [7:0]       pend_char_q;
	logic             pend_err_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             run_last_q;
	logic             error_seen_q;
	logic             out_ready;
	logic             out_load;

	assign pop       = cmd.emit_top || cmd.pop_drop;
	assign emit      = cmd.emit_top || cmd.emit_char;
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign out_ready = !out_valid_q || !out_stall;
	assign out_load  = pend_valid_q && (emit || cmd.drain);

	always_comb begin
		count_d = count_q;
		if (cmd.push)
			count_d = count_q + CNT_W'(1);
		else if (pop)
			count_d = count_q - CNT_W'(1);
	end

	assign count_m1 = count_d - CNT_W'(1);
	assign rd_addr  = count_m1[PTR_W-1:0];

	// error this item will raise, judged before any pops
	always_comb begin
		unique case (char_class(in_char))
			CLS_OPEN:  item_err = full;
			CLS_CLOSE: item_err = (paren_q == '0);
			CLS_OTHER: item_err = full && !pops_entry(top_q, in_char);
			default:   item_err = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.push)
			stack_mem[count_q[PTR_W-1:0]] <= ch_q;
	end

	// top entry follows the depth it will have; forward a push
	always_ff @(posedge clk) begin
		if (cmd.push)
			top_q <= ch_q;
		else
			top_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q  <= in_char;
			eos_q <= end_of_string;
		end
		if (emit) begin
			pend_char_q <= cmd.emit_char ? ch_q : top_q;
			pend_err_q  <= err_q;
		end
		if (out_load) begin
			out_char_q   <= pend_char_q;
			run_last_q   <= cmd.drain;
			error_seen_q <= pend_err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			paren_q      <= '0;
			err_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.push && ch_q == CH_OPEN)
				paren_q <= paren_q + CNT_W'(1);
			else if (pop && top_q == CH_OPEN)
				paren_q <= paren_q - CNT_W'(1);
			if (cmd.load)
				err_q <= err_q | item_err;
			else if (cmd.clear_err)
				err_q <= 1'b0;
			if (emit)
				pend_valid_q <= 1'b1;
			else if (cmd.drain)
				pend_valid_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.cls         = char_class(ch_q);
		stat.eos         = eos_q;
		stat.count_zero  = (count_q == '0);
		stat.full        = full;
		stat.top_is_open = (top_q == CH_OPEN);
		stat.top_pops    = pops_entry(top_q, ch_q);
		stat.pend_valid  = pend_valid_q;
		stat.out_ready   = out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign run_last   = run_last_q;
	assign error_seen = error_seen_q;

endmodule

[hdl/i2p_ctrl.sv]
// ----------------------------------------------------------------------------
// i2p_ctrl
// Controller: accepts one character, then steps the shunting-yard decisions
// one stack operation per cycle unless stalled, and flushes at end of string.
// ----------------------------------------------------------------------------
module i2p_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  i2p_pkg::stat_t stat,
	output i2p_pkg::cmd_t  cmd
);
	import i2p_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   run_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		run_done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall  = stat.pend_valid && !stat.out_ready;
				cmd.drain = stat.pend_valid && stat.out_ready;
				if (in_valid && !in_stall) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				if (stat.out_ready) begin
					unique case (stat.cls)
						CLS_ALNUM: begin
							cmd.emit_char = 1'b1;
							run_done      = 1'b1;
						end
						CLS_OPEN: begin
							cmd.push = !stat.full;
							run_done = 1'b1;
						end
						CLS_CLOSE: begin
							if (stat.count_zero) begin
								run_done = 1'b1;
							end else if (stat.top_is_open) begin
								cmd.pop_drop = 1'b1;
								run_done     = 1'b1;
							end else begin
								cmd.emit_top = 1'b1;
							end
						end
						CLS_OTHER: begin
							if (!stat.count_zero && stat.top_pops) begin
								cmd.emit_top = 1'b1;
							end else begin
								cmd.push = !stat.full;
								run_done = 1'b1;
							end
						end
					endcase
					if (run_done)
						state_d = stat.eos ? S_FLUSH : S_IDLE;
				end
			end
			S_FLUSH: begin
				if (stat.out_ready) begin
					if (!stat.count_zero) begin
						cmd.emit_top = 1'b1;
					end else begin
						cmd.clear_err = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[hdl/infix_to_postfix_converter.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from a stream of infix characters to postfix.
//
// Input channel (in_valid/in_stall): one character per transfer, with
// end_of_string marking the last character of an expression.
// Output channel (out_valid/out_stall): postfix characters; run_last marks the
// last character caused by one input transfer, error_seen carries the sticky
// error flag (unmatched close bracket or full stack) of the current string.
// An input that causes no output produces no transfer at all.
// Order of work: a transfer is taken in an idle cycle, then the run state pops
// stack entries and ends with the decision on the character; a letter, digit
// or non-popping operator needs only that decision. End of string adds a flush
// of the remaining entries. Each result waits in a lookahead register so that
// run_last is known, and leaves when the next result is made or the run drains.
// The pop loop of the stack (one entry per cycle unless stalled) sets the rate.
// When the receiver stalls, the output register holds and work pauses.
// Reset empties the stack and clears the error flag; the stack memory itself
// is not cleared.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_last,
	output logic       error_seen
);
	import i2p_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	i2p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	i2p_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_char       (in_char),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_char      (out_char),
		.run_last      (run_last),
		.error_seen    (error_seen)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full)
		else $error("push issued on a full stack");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_top || cmd.pop_drop) |-> !stat.count_zero)
		else $error("pop issued on an empty stack");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.emit_top || cmd.emit_char) && stat.pend_valid) |-> stat.out_ready)
		else $error("lookahead result overwritten while output is blocked");

	a_load_then_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> in_stall)
		else $error("new transfer taken before the previous one was processed");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the infix-to-postfix converter. Character strings
// (directed cases, then random expressions with some noise and broken input)
// go into the block over the valid/stall channel. A local operator-stack
// model predicts every postfix character with its run_last and error_seen
// bits, and each output transfer is checked against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import i2p_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 10;
	localparam int TAIL_CYCLES  = 2 * STACK_DEPTH + 20;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 290;

	// precedence levels of the shunting-yard rules
	localparam int PREC_POW  = 3;
	localparam int PREC_MUL  = 2;
	localparam int PREC_ADD  = 1;
	localparam int PREC_NONE = -1;

	// receiver stall patterns
	localparam int STALL_NONE     = 0;
	localparam int STALL_RANDOM   = 1;
	localparam int STALL_PERIODIC = 2;
	localparam int STALL_HEAVY    = 3;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       err;
	} postfix_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_stall;
	logic [7:0] in_char       = 8'h00;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_stall     = 1'b0;
	logic [7:0] out_char;
	logic       run_last;
	logic       error_seen;

	// operator stack model
	logic [7:0] model_stack [STACK_DEPTH];
	int         model_depth = 0;
	logic       model_err   = 1'b0;

	postfix_t   expected_postfix [$];

	int  fail_count     = 0;
	int  cycle_count    = 0;
	int  chars_sent     = 0;
	int  strings_ended  = 0;
	int  results_seen   = 0;
	int  error_results  = 0;
	int  stall_mode     = STALL_NONE;
	int  stall_phase    = 0;
	bit  sender_gaps    = 1'b0;
	int  burst_left     = 0;

	infix_to_postfix_converter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_char      (in_char),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.run_last     (run_last),
		.error_seen   (error_seen)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
			         expected_postfix.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- model

	function automatic int precedence(input logic [7:0] ch);
		int p;
		if (ch == CH_CARET)
			p = PREC_POW;
		else if (ch == CH_STAR || ch == CH_SLASH)
			p = PREC_MUL;
		else if (ch == CH_PLUS || ch == CH_MINUS)
			p = PREC_ADD;
		else
			p = PREC_NONE;
		return p;
	endfunction

	function automatic bit is_operand(input logic [7:0] ch);
		return (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z") ||
		       (ch >= "a" && ch <= "z");
	endfunction

	task automatic push_operator(input logic [7:0] ch);
		if (model_depth >= STACK_DEPTH) begin
			model_err = 1'b1;
		end else begin
			model_stack[model_depth] = ch;
			model_depth++;
		end
	endtask

	// Work out the postfix characters one accepted input causes.
	task automatic predict_postfix(input logic [7:0] ch, input logic eos);
		logic [7:0] emitted [$];
		logic [7:0] top;
		postfix_t   item;
		int         p;
		if (is_operand(ch)) begin
			emitted.push_back(ch);
		end else if (ch == CH_OPEN) begin
			push_operator(ch);
		end else if (ch == CH_CLOSE) begin
			if (model_depth == 0) begin
				model_err = 1'b1;
			end else begin
				while (model_depth > 0 && model_stack[model_depth - 1] != CH_OPEN) begin
					model_depth--;
					emitted.push_back(model_stack[model_depth]);
				end
				if (model_depth > 0)
					model_depth--;
				else
					model_err = 1'b1;
			end
		end else begin
			p = precedence(ch);
			while (model_depth > 0) begin
				top = model_stack[model_depth - 1];
				if (precedence(top) < p)
					break;
				// caret is right-associative
				if (ch == CH_CARET && top == CH_CARET)
					break;
				model_depth--;
				emitted.push_back(top);
			end
			push_operator(ch);
		end
		if (eos) begin
			while (model_depth > 0) begin
				model_depth--;
				emitted.push_back(model_stack[model_depth]);
			end
		end
		foreach (emitted[k]) begin
			item.ch   = emitted[k];
			item.last = (k == emitted.size() - 1);
			item.err  = model_err;
			expected_postfix.push_back(item);
		end
		if (eos)
			model_err = 1'b0;
	endtask

	// --------------------------------------------------------------- driving

	// Call at a falling edge; returns at the falling edge after the transfer.
	task automatic send_char(input logic [7:0] ch, input logic eos);
		if (sender_gaps && burst_left == 0) begin
			in_valid <= 1'b0;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(6, 20)) @(negedge clk);
			else
				repeat ($urandom_range(1, 4)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_valid      <= 1'b1;
		in_char       <= ch;
		end_of_string <= eos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_postfix(ch, eos);
		chars_sent++;
		if (eos)
			strings_ended++;
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input bit eos_last);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], eos_last && (i == s.len() - 1));
	endtask

	task automatic send_bytes(input logic [7:0] text [$]);
		foreach (text[i])
			send_char(text[i], i == text.size() - 1);
	endtask

	always @(negedge clk) begin
		stall_phase++;
		case (stall_mode)
			STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
			STALL_PERIODIC: out_stall <= ((stall_phase % 7) < 3);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
			default:        out_stall <= 1'b0;
		endcase
	end

	// -------------------------------------------------------------- checking

	always @(posedge clk) begin
		postfix_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			results_seen++;
			if (error_seen === 1'b1)
				error_results++;
			if (expected_postfix.size() == 0) begin
				$error("unexpected transfer: out_char %02h run_last %0b error_seen %0b",
				       out_char, run_last, error_seen);
				fail_count++;
			end else begin
				want = expected_postfix.pop_front();
				if (out_char !== want.ch) begin
					$error("out_char: expected %02h, got %02h", want.ch, out_char);
					fail_count++;
				end
				if (run_last !== want.last) begin
					$error("run_last: expected %0b, got %0b", want.last, run_last);
					fail_count++;
				end
				if (error_seen !== want.err) begin
					$error("error_seen: expected %0b, got %0b", want.err, error_seen);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------ generators

	function automatic logic [7:0] random_operand();
		int r;
		logic [7:0] ch;
		r = $urandom_range(0, 61);
		if (r < 10)
			ch = 8'("0" + r);
		else if (r < 36)
			ch = 8'("A" + r - 10);
		else
			ch = 8'("a" + r - 36);
		return ch;
	endfunction

	function automatic logic [7:0] random_operator();
		logic [7:0] ch;
		case ($urandom_range(0, 4))
			0:       ch = CH_CARET;
			1:       ch = CH_STAR;
			2:       ch = CH_SLASH;
			3:       ch = CH_PLUS;
			default: ch = CH_MINUS;
		endcase
		return ch;
	endfunction

	task automatic build_expression(output logic [7:0] text [$]);
		int operands;
		int nest;
		text     = {};
		nest     = 0;
		operands = $urandom_range(1, 8);
		for (int i = 0; i < operands; i++) begin
			while (nest < 6 && $urandom_range(0, 3) == 0) begin
				text.push_back(CH_OPEN);
				nest++;
			end
			text.push_back(random_operand());
			while (nest > 0 && $urandom_range(0, 2) == 0) begin
				text.push_back(CH_CLOSE);
				nest--;
			end
			if (i < operands - 1)
				text.push_back(random_operator());
		end
		// leave an occasional open bracket for the flush to emit
		while (nest > 0 && $urandom_range(0, 5) != 0) begin
			text.push_back(CH_CLOSE);
			nest--;
		end
	endtask

	// ----------------------------------------------------------------- tests

	task automatic test_operands();
		send_text("Az", 1'b1);
	endtask

	task automatic test_precedence();
		// right-associative caret, then lower levels pop it
		send_text("0^Z^c/9-a", 1'b1);
	endtask

	task automatic test_brackets();
		send_text("(a+b)*c", 1'b1);
	endtask

	task automatic test_error_cases();
		send_char(CH_CLOSE, 1'b0);        // close on empty stack
		send_char(CH_OPEN, 1'b0);
		send_char(8'hFF, 1'b0);           // no-precedence byte pops the open bracket
		send_char(8'h00, 1'b0);           // and pops another no-precedence byte
		send_char(CH_CLOSE, 1'b0);        // no matching open bracket
		send_text("q", 1'b1);
	endtask

	task automatic test_overflow();
		stall_mode = STALL_RANDOM;
		repeat (STACK_DEPTH + 1)
			send_char(CH_OPEN, 1'b0);
		send_char(CH_PLUS, 1'b0);
		send_text("x", 1'b1);
	endtask

	task automatic test_random();
		logic [7:0] text [$];
		int         sent;
		int         kind;
		int         pos;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// cycle sender and receiver idling every quarter
			case ((4 * sent) / RANDOM_ITEMS)
				0:       begin sender_gaps = 1'b0; stall_mode = STALL_NONE;     end
				1:       begin sender_gaps = 1'b1; stall_mode = STALL_RANDOM;   end
				2:       begin sender_gaps = 1'b0; stall_mode = STALL_PERIODIC; end
				default: begin sender_gaps = 1'b1; stall_mode = STALL_HEAVY;    end
			endcase
			kind = $urandom_range(0, 19);
			if (kind < 13) begin
				build_expression(text);
				send_bytes(text);
				sent += text.size();
			end else if (kind < 16) begin
				// corrupt an expression: stray close bracket or dropped character
				build_expression(text);
				pos = $urandom_range(0, text.size() - 1);
				if ($urandom_range(0, 1) == 0)
					text.insert(pos, CH_CLOSE);
				else if (text.size() > 1)
					text.delete(pos);
				send_bytes(text);
				sent += text.size();
			end else if (kind < 19) begin
				repeat ($urandom_range(1, 6)) begin
					send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
					sent++;
				end
			end else begin
				// nest close to or past the stack depth
				text = {};
				repeat ($urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 3))
					text.push_back(CH_OPEN);
				text.push_back(random_operand());
				send_bytes(text);
				sent += text.size();
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_operands();
		test_precedence();
		sender_gaps = 1'b1;
		stall_mode  = STALL_PERIODIC;
		test_brackets();
		test_error_cases();
		test_overflow();
		test_random();
		in_valid <= 1'b0;

		while (expected_postfix.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d characters in %0d strings; checked %0d postfix results",
		         chars_sent, strings_ended, results_seen);
		$display("%0d results carried the error flag (overflow, stray close bracket)",
		         error_results);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
